FILE: sv/sglap_pkg.sv
// shared types, constants and sine helper for the stereo gain / lfo auto-pan block
package sglap_pkg;

    // default parameter values
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;

    // fixed point
    localparam int Q14_FRAC = 14;
    localparam int Q14_ONE  = 16384;
    localparam int MG_MAX   = 32768;

    // register and field widths
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int MG_W       = 16;
    localparam int PAN_W      = 16;
    localparam int STEP_W     = 24;
    localparam int DEPTH_W    = 15;
    localparam int Q14_W      = 15;   // 0 .. 1.0 unsigned
    localparam int SIN_W      = 16;   // -1.0 .. 1.0 signed
    localparam int GAIN_W     = 16;   // channel gain 0 .. 2.0
    localparam int MODG_W     = 17;   // modulated gain 0 .. 4.0
    localparam int MUL_B_W    = 18;   // signed operand b of the shared multiplier

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_GAIN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_POSITION = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH    = 8'd3;

    // polynomial coefficients of the quarter sine, Q30
    localparam logic [63:0] COEF1 = 64'd1686629713;
    localparam logic [63:0] COEF3 = 64'd693598668;
    localparam logic [63:0] COEF5 = 64'd85569306;
    localparam logic [63:0] COEF7 = 64'd5026995;
    localparam logic [63:0] COEF9 = 64'd172272;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LFO,
        ST_GL,
        ST_GR,
        ST_ML,
        ST_MR,
        ST_YL,
        ST_YR,
        ST_DONE
    } t_state;

    // sin(pi/2 * q / 2^qbits) as unsigned Q14, evaluated at elaboration
    function automatic logic [Q14_W-1:0] f_quarter_sine(input logic [31:0] q, input int qbits);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] v;
        t  = 64'(q) << (30 - qbits);
        t2 = (t * t) >> 30;
        p  = COEF9;
        p  = COEF7 - ((t2 * p) >> 30);
        p  = COEF5 - ((t2 * p) >> 30);
        p  = COEF3 - ((t2 * p) >> 30);
        p  = COEF1 - ((t2 * p) >> 30);
        v  = (t * p) >> 30;
        v  = (v + (64'd1 << 15)) >> 16;
        if (v > 64'(Q14_ONE)) begin
            v = 64'(Q14_ONE);
        end
        return Q14_W'(v);
    endfunction

endpackage

FILE: sv/stereo_gain_lfo_autopan_top.sv
// stereo master gain with sine lfo auto-pan, one shared multiplier under a sequencer
// an accepted input word steps through the states lfo, gl, gr, ml, mr, yl, yr and done before its result is valid
// no new stereo word is taken until the last one has left done; seven products share one multiplier
// an input is accepted only in idle; a finished result waits in the output register
// reset (i_rst_n low, synchronous): registers to defaults, lfo phase zero, no output
module stereo_gain_lfo_autopan_top #(
    parameter int SAMPLE_BITS    = sglap_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS     = sglap_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = sglap_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]       i_right_in,
    // result words
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_left_out,
    output logic signed [SAMPLE_BITS-1:0]       o_right_out,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sglap_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sglap_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sglap_pkg::*;

    localparam int AW     = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
    localparam int BW     = MUL_B_W;
    localparam int RW     = AW + BW - Q14_FRAC;
    localparam int QBITS  = SINE_ADDR_BITS - 2;
    localparam int QN     = 1 << QBITS;
    localparam int IDX_W  = SINE_ADDR_BITS - 1;
    localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

    // quarter-wave sine rom, built at elaboration
    typedef logic [Q14_W-1:0] t_qsin_rom [QN+1];

    function automatic t_qsin_rom f_build_rom();
        t_qsin_rom rom;
        for (int i = 0; i <= QN; i++) begin
            rom[i] = f_quarter_sine(32'(i), QBITS);
        end
        return rom;
    endfunction

    localparam t_qsin_rom QSIN_ROM = f_build_rom();

    // registers
    t_state                       r_state;
    t_state                       n_state;
    logic [MG_W-1:0]              r_main_gain;
    logic signed [PAN_W-1:0]      r_pan;
    logic [STEP_W-1:0]            r_phase_step;
    logic [DEPTH_W-1:0]           r_depth;
    logic [PHASE_BITS-1:0]        r_phase;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic [Q14_W-1:0]             r_qsin;
    logic                         r_sin_neg;
    logic signed [SIN_W-1:0]      r_lfo;
    logic [GAIN_W-1:0]            r_gl;
    logic [GAIN_W-1:0]            r_gr;
    logic [MODG_W-1:0]            r_gain_l;
    logic [MODG_W-1:0]            r_gain_r;
    logic signed [SAMPLE_BITS-1:0] r_yl;
    logic                         r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;

    // combinational signals
    logic [MG_W-1:0]              w_mg;
    logic signed [PAN_W-1:0]      w_p;
    logic signed [PAN_W:0]        w_pl_s;
    logic signed [PAN_W:0]        w_pr_s;
    logic [Q14_W-1:0]             w_pan_l;
    logic [Q14_W-1:0]             w_pan_r;
    logic [DEPTH_W-1:0]           w_depth;
    logic                         w_lfo_on;
    logic signed [BW-1:0]         w_mod_l;
    logic signed [BW-1:0]         w_mod_r;
    logic [SINE_ADDR_BITS-1:0]    w_addr;
    logic [1:0]                   w_quad;
    logic [QBITS-1:0]             w_q;
    logic [IDX_W-1:0]             w_rom_idx;
    logic signed [SIN_W-1:0]      w_sin;
    logic                         w_mul_en;
    logic signed [AW-1:0]         w_a;
    logic signed [BW-1:0]         w_b;
    logic signed [RW-1:0]         w_prod;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    logic                         w_out_free;

    // clamped register values and pan factors
    always_comb begin
        w_mg    = (r_main_gain > MG_W'(MG_MAX)) ? MG_W'(MG_MAX) : r_main_gain;
        w_depth = (r_depth > DEPTH_W'(Q14_ONE)) ? DEPTH_W'(Q14_ONE) : r_depth;
        if (r_pan < -PAN_W'(Q14_ONE)) begin
            w_p = -PAN_W'(Q14_ONE);
        end else if (r_pan > PAN_W'(Q14_ONE)) begin
            w_p = PAN_W'(Q14_ONE);
        end else begin
            w_p = r_pan;
        end
        w_pl_s = (PAN_W + 1)'(Q14_ONE) - (PAN_W + 1)'(w_p);
        w_pr_s = (PAN_W + 1)'(Q14_ONE) + (PAN_W + 1)'(w_p);
        if (w_p <= 0) begin
            w_pan_l = Q14_W'(Q14_ONE);
            w_pan_r = w_pr_s[Q14_W-1:0];
        end else begin
            w_pan_l = w_pl_s[Q14_W-1:0];
            w_pan_r = Q14_W'(Q14_ONE);
        end
        w_lfo_on = (r_phase_step != '0) && (w_depth != '0);
    end

    // lfo modulation factors
    always_comb begin
        if (w_lfo_on) begin
            w_mod_l = BW'(Q14_ONE) - BW'(r_lfo);
            w_mod_r = BW'(Q14_ONE) + BW'(r_lfo);
        end else begin
            w_mod_l = BW'(Q14_ONE);
            w_mod_r = BW'(Q14_ONE);
        end
    end

    // sine rom address by quarter-wave symmetry
    always_comb begin
        w_addr = r_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
        w_quad = w_addr[SINE_ADDR_BITS-1 -: 2];
        w_q    = w_addr[QBITS-1:0];
        if (w_quad[0]) begin
            w_rom_idx = IDX_W'(QN) - IDX_W'(w_q);
        end else begin
            w_rom_idx = IDX_W'(w_q);
        end
        w_sin = r_sin_neg ? -SIN_W'(r_qsin) : SIN_W'(r_qsin);
    end

    // registered rom read, follows the phase every cycle
    always_ff @(posedge i_clk) begin
        r_qsin    <= QSIN_ROM[w_rom_idx];
        r_sin_neg <= w_quad[1];
    end

    // saturation of the rounded sample product
    always_comb begin
        priority if (w_prod > SAT_HI) begin
            w_sat = SAMPLE_BITS'(SAT_HI);
        end else if (w_prod < SAT_LO) begin
            w_sat = SAMPLE_BITS'(SAT_LO);
        end else begin
            w_sat = SAMPLE_BITS'(w_prod);
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LFO;
                end
            end
            ST_LFO:  n_state = ST_GL;
            ST_GL:   n_state = ST_GR;
            ST_GR:   n_state = ST_ML;
            ST_ML:   n_state = ST_MR;
            ST_MR:   n_state = ST_YL;
            ST_YL:   n_state = ST_YR;
            ST_YR:   n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // multiplier operand selection
    always_comb begin
        w_mul_en = 1'b1;
        w_a      = '0;
        w_b      = '0;
        unique case (r_state)
            ST_LFO: begin
                w_a = AW'(w_sin);
                w_b = BW'(w_depth);
            end
            ST_GL: begin
                w_a = AW'(w_mg);
                w_b = BW'(w_pan_l);
            end
            ST_GR: begin
                w_a = AW'(w_mg);
                w_b = BW'(w_pan_r);
            end
            ST_ML: begin
                w_a = AW'(r_gl);
                w_b = w_mod_l;
            end
            ST_MR: begin
                w_a = AW'(r_gr);
                w_b = w_mod_r;
            end
            ST_YL: begin
                w_a = AW'(r_left);
                w_b = BW'(r_gain_l);
            end
            ST_YR: begin
                w_a = AW'(r_right);
                w_b = BW'(r_gain_r);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    // shared multiplier
    sglap_mul #(
        .A_W (AW),
        .B_W (BW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // control state, registers and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_main_gain   <= MG_W'(Q14_ONE);
            r_pan         <= '0;
            r_phase_step  <= '0;
            r_depth       <= '0;
            r_phase       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAIN_GAIN:    r_main_gain   <= i_cfg_data[MG_W-1:0];
                    CFG_PAN_POSITION: r_pan         <= i_cfg_data[PAN_W-1:0];
                    CFG_PHASE_STEP:   r_phase_step  <= i_cfg_data[STEP_W-1:0];
                    CFG_MOD_DEPTH:    r_depth       <= i_cfg_data[DEPTH_W-1:0];
                    default: ;
                endcase
            end
            // a new word replaces one that leaves in the same cycle
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
                if (w_lfo_on) begin
                    r_phase <= r_phase + PHASE_BITS'(r_phase_step);
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: each product is registered in the multiplier, then stored in its destination in the next state
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_left  <= i_left_in;
                    r_right <= i_right_in;
                end
            end
            ST_LFO: ;
            ST_GL:  r_lfo    <= w_prod[SIN_W-1:0];
            ST_GR:  r_gl     <= w_prod[GAIN_W-1:0];
            ST_ML:  r_gr     <= w_prod[GAIN_W-1:0];
            ST_MR:  r_gain_l <= w_prod[MODG_W-1:0];
            ST_YL:  r_gain_r <= w_prod[MODG_W-1:0];
            ST_YR:  r_yl     <= w_sat;
            ST_DONE: begin
                if (w_out_free) begin
                    r_left_out  <= r_yl;
                    r_right_out <= w_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: sv/sglap_mul.sv
// shared signed multiplier with q14 rounding and a registered product
module sglap_mul #(
    parameter int A_W = 25,
    parameter int B_W = 18
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [A_W-1:0]             i_a,
    input  logic signed [B_W-1:0]             i_b,
    output logic signed [A_W+B_W-sglap_pkg::Q14_FRAC-1:0] o_prod
);
    import sglap_pkg::*;

    localparam int FULL_W = A_W + B_W;

    logic signed [FULL_W-1:0] w_full;
    logic        [FULL_W-1:0] w_rnd;
    logic signed [FULL_W-Q14_FRAC-1:0] r_prod;

    // product plus half an lsb, then floor by dropping the fraction
    always_comb begin
        w_full = FULL_W'(i_a) * FULL_W'(i_b);
        w_rnd  = w_full + (FULL_W'(1) << (Q14_FRAC - 1));
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_rnd[FULL_W-1:Q14_FRAC];
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: tb/sv/tb_autopan_pkg.sv
`timescale 1ns / 1ps
// scoreboard class that predicts and checks the scaled stereo words
package tb_autopan_pkg;
    import sglap_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int PW = PHASE_BITS_DEF;
    localparam int AW = SINE_ADDR_BITS_DEF;

    localparam longint UNITY = Q14_ONE;
    localparam longint GAIN_CAP = MG_MAX;

    // odd polynomial of the quarter sine, Q30
    localparam longint unsigned SIN_C1 = 64'd1686629713;
    localparam longint unsigned SIN_C3 = 64'd693598668;
    localparam longint unsigned SIN_C5 = 64'd85569306;
    localparam longint unsigned SIN_C7 = 64'd5026995;
    localparam longint unsigned SIN_C9 = 64'd172272;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } stereo_pair_t;

    class autopan_scoreboard;
        logic [MG_W-1:0]           main_gain;
        logic signed [PAN_W-1:0]   pan_position;
        logic [STEP_W-1:0]         phase_step;
        logic [DEPTH_W-1:0]        mod_depth;
        logic [PW-1:0]             lfo_phase;
        int                        sine_q14 [1 << AW];
        stereo_pair_t              expected_pairs [$];
        int                        mismatches;

        // register defaults and the sine table, built by quarter-wave symmetry
        function new();
            int qbits;
            int quad;
            longint unsigned q;
            longint unsigned t;
            longint unsigned t2;
            longint unsigned p;
            longint unsigned v;
            main_gain    = MG_W'(Q14_ONE);
            pan_position = '0;
            phase_step   = '0;
            mod_depth    = '0;
            lfo_phase    = '0;
            mismatches   = 0;
            qbits = AW - 2;
            for (int a = 0; a < (1 << AW); a++) begin
                quad = (a >> qbits) & 3;
                q = a & ((1 << qbits) - 1);
                if (quad & 1) begin
                    q = (1 << qbits) - q;
                end
                t  = q << (30 - qbits);
                t2 = (t * t) >> 30;
                p  = SIN_C9;
                p  = SIN_C7 - ((t2 * p) >> 30);
                p  = SIN_C5 - ((t2 * p) >> 30);
                p  = SIN_C3 - ((t2 * p) >> 30);
                p  = SIN_C1 - ((t2 * p) >> 30);
                v  = (t * p) >> 30;
                v  = (v + (64'd1 << 15)) >> 16;
                if (v > 64'(Q14_ONE)) begin
                    v = 64'(Q14_ONE);
                end
                sine_q14[a] = (quad & 2) ? -int'(v) : int'(v);
            end
        endfunction

        // add half an lsb then floor, q14
        function longint q14_round(longint x);
            return (x + (UNITY / 2)) >>> Q14_FRAC;
        endfunction

        // apply channel gain and modulation, saturate to the sample range
        function sample_t scaled(sample_t x, longint g, longint m);
            longint y;
            longint top;
            top = (longint'(1) <<< (SW - 1)) - 1;
            y = q14_round(longint'(x) * q14_round(g * m));
            if (y > top) begin
                y = top;
            end
            if (y < -top - 1) begin
                y = -top - 1;
            end
            return sample_t'(y);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAIN_GAIN:    main_gain    = data[MG_W-1:0];
                CFG_PAN_POSITION: pan_position = data[PAN_W-1:0];
                CFG_PHASE_STEP:   phase_step   = data[STEP_W-1:0];
                CFG_MOD_DEPTH:    mod_depth    = data[DEPTH_W-1:0];
                default: ;
            endcase
        endfunction

        // accepted input word: work out the scaled pair and advance the lfo
        function void take_pair(sample_t l, sample_t r);
            longint mg;
            longint pan;
            longint dep;
            longint pl;
            longint pr;
            longint gl;
            longint gr;
            longint ml;
            longint mr;
            longint lfo;
            stereo_pair_t e;
            mg = longint'(main_gain);
            if (mg > GAIN_CAP) begin
                mg = GAIN_CAP;
            end
            pan = longint'(pan_position);
            if (pan < -UNITY) begin
                pan = -UNITY;
            end
            if (pan > UNITY) begin
                pan = UNITY;
            end
            if (pan <= 0) begin
                pl = UNITY;
                pr = UNITY + pan;
            end else begin
                pl = UNITY - pan;
                pr = UNITY;
            end
            gl = q14_round(mg * pl);
            gr = q14_round(mg * pr);
            dep = longint'(mod_depth);
            if (dep > UNITY) begin
                dep = UNITY;
            end
            ml = UNITY;
            mr = UNITY;
            // lfo runs only with both step and depth nonzero
            if (phase_step != 0 && dep != 0) begin
                lfo = q14_round(dep * longint'(sine_q14[lfo_phase[PW-1 -: AW]]));
                ml = UNITY - lfo;
                mr = UNITY + lfo;
                lfo_phase = lfo_phase + PW'(phase_step);
            end
            e.left  = scaled(l, gl, ml);
            e.right = scaled(r, gr, mr);
            expected_pairs.push_back(e);
        endfunction

        // result word against the oldest expectation
        function void match_pair(sample_t l, sample_t r);
            stereo_pair_t e;
            if (expected_pairs.size() == 0) begin
                $display("%0t: result word with nothing expected, left %0d right %0d",
                         $time, l, r);
                mismatches++;
                return;
            end
            e = expected_pairs.pop_front();
            if (l !== e.left) begin
                $display("%0t: left_out expected %0d got %0d", $time, e.left, l);
                mismatches++;
            end
            if (r !== e.right) begin
                $display("%0t: right_out expected %0d got %0d", $time, e.right, r);
                mismatches++;
            end
        endfunction

        function int pending_count();
            return expected_pairs.size();
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_stereo_gain_lfo_autopan_top.sv
`timescale 1ns / 1ps
// testbench top for the stereo gain / lfo auto-pan block
module tb_stereo_gain_lfo_autopan_top;
    import sglap_pkg::*;
    import tb_autopan_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int DUT_LATENCY   = 8;
    localparam int SETTLE_CYCLES = DUT_LATENCY + 4;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int WRAP_ITEMS    = 260;
    localparam int TOTAL_ITEMS   = 620;
    localparam int CFG_IDX_FIRST_UNUSED = 4;

    localparam sample_t S_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam sample_t S_MIN = {1'b1, {(SW - 1){1'b0}}};

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    sample_t                 i_left_in;
    sample_t                 i_right_in;
    logic                    o_out_valid;
    logic                    i_out_ready;
    sample_t                 o_left_out;
    sample_t                 o_right_out;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    autopan_scoreboard board = new();
    int  cycle_count = 0;
    int  items_sent;
    bit  quiet_run;

    stereo_gain_lfo_autopan_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none in a quiet run
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run) begin
            return 0;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t next_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return sample_t'($urandom_range(0, 32) - 16);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // input word: valid held with fixed payload until taken
    task automatic push_pair(input sample_t l, input sample_t r);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_in_ready === 1'b1);
            if (taken) begin
                board.take_pair(l, r);
                items_sent++;
            end
            @(posedge i_clk);
        end
    endtask

    // register write word, with valid dropped again after it is taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_cfg_ready === 1'b1);
            if (taken) begin
                board.set_reg(idx, data);
            end
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off input until every expected word is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_items(input int n);
        for (int i = 0; i < n; i++) begin
            push_pair(next_sample(), next_sample());
            if ($urandom_range(0, 63) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // random register settings, extremes and out-of-range values included
    task automatic pick_settings();
        logic [CFG_DATA_W-1:0] mg;
        logic [CFG_DATA_W-1:0] pan;
        logic [CFG_DATA_W-1:0] step;
        logic [CFG_DATA_W-1:0] depth;
        case ($urandom_range(0, 4))
            0: mg = '0;
            1: mg = CFG_DATA_W'(MG_MAX);
            2: mg = CFG_DATA_W'($urandom_range(MG_MAX + 1, 16'hFFFF));
            3: mg = CFG_DATA_W'($urandom_range(0, MG_MAX));
            default: mg = CFG_DATA_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: pan = CFG_DATA_W'(-Q14_ONE);
            1: pan = CFG_DATA_W'(Q14_ONE);
            2: pan = '0;
            3: pan = CFG_DATA_W'($urandom_range(0, 2 * Q14_ONE) - Q14_ONE);
            default: pan = CFG_DATA_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: step = '0;
            1: step = {CFG_DATA_W{1'b1}};
            2: step = CFG_DATA_W'($urandom_range(1, 4095));
            default: step = CFG_DATA_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: depth = '0;
            1: depth = CFG_DATA_W'(Q14_ONE);
            3: depth = CFG_DATA_W'($urandom);
            default: depth = CFG_DATA_W'($urandom_range(1, Q14_ONE));
        endcase
        write_reg(CFG_MAIN_GAIN, mg);
        write_reg(CFG_PAN_POSITION, pan);
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_MOD_DEPTH, depth);
        // writes to indexes past the register list are dropped
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_FIRST_UNUSED, {CFG_IDX_W{1'b1}})),
                      CFG_DATA_W'($urandom));
        end
    endtask

    // result side: ready in random runs with random stalls
    initial begin : result_side
        int run;
        int gap;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            run = $urandom_range(1, 40);
            gap = pick_gap();
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // result words are checked where they are taken
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            board.match_pair(o_left_out, o_right_out);
        end
    end

    // stimulus
    initial begin : stimulus
        items_sent  = 0;
        quiet_run   = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_left_in   <= '0;
        i_right_in  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: unity gain, center pan, lfo off
        push_pair(S_MAX, S_MAX);
        push_pair(S_MIN, S_MIN);
        push_pair('0, '0);
        push_pair(sample_t'(1), sample_t'(-1));
        wait_drained();

        // master gain above the cap, pan above full right
        write_reg(CFG_MAIN_GAIN, 24'h00FFFF);
        write_reg(CFG_PAN_POSITION, 24'h007FFF);
        push_pair(S_MAX, S_MIN);
        push_pair(S_MIN, S_MAX);
        push_pair(sample_t'(24'h400000), sample_t'(24'hBFFFFF));
        wait_drained();

        // pan below full left, depth above the cap, largest step
        write_reg(CFG_MAIN_GAIN, CFG_DATA_W'(MG_MAX));
        write_reg(CFG_PAN_POSITION, 24'hFF8000);
        write_reg(CFG_PHASE_STEP, {CFG_DATA_W{1'b1}});
        write_reg(CFG_MOD_DEPTH, 24'hFF7FFF);
        push_pair(S_MAX, S_MAX);
        push_pair(S_MIN, S_MIN);
        push_pair(S_MAX, S_MIN);
        push_pair(sample_t'(-1), sample_t'(1));
        wait_drained();

        // zero master gain, exact full left, full depth, smallest step
        write_reg(CFG_MAIN_GAIN, '0);
        write_reg(CFG_PAN_POSITION, CFG_DATA_W'(-Q14_ONE));
        write_reg(CFG_PHASE_STEP, 24'd1);
        write_reg(CFG_MOD_DEPTH, CFG_DATA_W'(Q14_ONE));
        push_pair(S_MAX, S_MIN);
        push_pair(S_MIN, S_MAX);
        wait_drained();

        // step zero with depth set: phase holds
        write_reg(CFG_MAIN_GAIN, 24'd32767);
        write_reg(CFG_PAN_POSITION, CFG_DATA_W'(Q14_ONE));
        write_reg(CFG_PHASE_STEP, '0);
        write_reg(CFG_MOD_DEPTH, 24'd100);
        push_pair(S_MAX, S_MAX);
        push_pair(S_MIN, S_MIN);
        wait_drained();

        // unknown indexes ignored; depth zero with step set keeps the lfo off
        write_reg(CFG_IDX_W'(CFG_IDX_FIRST_UNUSED), {CFG_DATA_W{1'b1}});
        write_reg({CFG_IDX_W{1'b1}}, '0);
        write_reg(CFG_PHASE_STEP, 24'h123456);
        write_reg(CFG_MOD_DEPTH, '0);
        push_pair(S_MAX, S_MIN);
        push_pair(sample_t'(24'h555555), sample_t'(24'hAAAAAA));
        wait_drained();

        // lfo sweep at the largest step, long enough for the phase to wrap
        write_reg(CFG_MAIN_GAIN, CFG_DATA_W'($urandom_range(0, MG_MAX)));
        write_reg(CFG_PAN_POSITION, CFG_DATA_W'($urandom_range(0, 2 * Q14_ONE) - Q14_ONE));
        write_reg(CFG_PHASE_STEP, {CFG_DATA_W{1'b1}});
        write_reg(CFG_MOD_DEPTH, CFG_DATA_W'($urandom_range(1, 16'h7FFF)));
        run_items(WRAP_ITEMS);

        // random settings, random words
        while (items_sent < TOTAL_ITEMS) begin
            pick_settings();
            quiet_run = ($urandom_range(0, 4) == 0);
            run_items($urandom_range(20, 60));
        end

        if (board.mismatches == 0 && board.pending_count() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
